// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros expect signals named clk and rst_n in the enclosing module.

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/ledd_pkg.sv
package ledd_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] dithered;
    logic [7:0] luma;
    logic       row_end;
  } pix_out_t;

  // Classified pixel as it travels from the front end to the back end.
  typedef struct packed {
    logic [7:0] luma;
    logic       last;
    logic       first_row;
    logic       frame_start;
  } item_ctl_t;

  // Register indexes, decoded from paddr[2].
  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_LEVELS     = 1'b1;

  localparam logic [12:0] LINE_WIDTH_RST = 13'd640;
  localparam logic [8:0]  LEVELS_RST     = 9'd70;

  // BT.601 weights in thousandths, plus the rounding bias.
  localparam logic [17:0] LUMA_KR   = 18'd299;
  localparam logic [17:0] LUMA_KG   = 18'd587;
  localparam logic [17:0] LUMA_KB   = 18'd114;
  localparam logic [17:0] LUMA_BIAS = 18'd500;

  // Division by 1000 as a multiplication by ceil(2^28/1000), exact for sums below 2^18.
  localparam logic [18:0] LUMA_RECIP = 19'd268436;
  localparam int          LUMA_SHIFT = 28;

  // Level index: floor((v*n + 2040) / 4080) = floor(((v*n + 2040) >> 4) / 255).
  localparam logic [19:0] IDX_BIAS  = 20'd2040;
  localparam logic [16:0] IDX_RECIP = 17'd65794;
  localparam int          IDX_SHIFT = 24;

  localparam logic [11:0] VAL_MAX = 12'd4080;

  // Floyd-Steinberg weights in sixteenths.
  localparam logic signed [23:0] K_RIGHT = 24'sd7;
  localparam logic signed [23:0] K_BL    = 24'sd3;
  localparam logic signed [23:0] K_BELOW = 24'sd5;
  localparam logic signed [23:0] K_BR    = 24'sd1;

  localparam int QUEUE_DEPTH = 4;

  // Rounded share of a weighted error: floor((p + 8) / 16).
  function automatic logic signed [23:0] share(input logic signed [23:0] p);
    logic signed [23:0] t;
    t = p + 24'sd8;
    return t >>> 4;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [23:0] v);
    logic [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'h7fff;
    end else if (v < -24'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [23:0] sx24(input logic [15:0] v);
    return $signed({{8{v[15]}}, v});
  endfunction

endpackage

// File: design/ledd_fifo.sv
`include "assert_macros.svh"

module ledd_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] din,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] dout,
  output logic          empty
);
  import ledd_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [DW-1:0] slot_r [QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == (AW+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= din;
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, push, !full, "queue written while full")
  `ASSERT_IMPLIES(a_no_underflow, pop, !empty, "queue read while empty")

endmodule

// File: design/ledd_front.sv
module ledd_front #(
  parameter int  MAX_WIDTH = 4096,
  localparam int CLW = $clog2(MAX_WIDTH),
  localparam int WW  = (CLW + 1 > 13) ? CLW + 1 : 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ledd_pkg::pix_in_t   in_data,
  input  logic [WW-1:0]       width_eff,
  output logic                push,
  output ledd_pkg::item_ctl_t push_ctl,
  output logic [CLW-1:0]      push_col,
  input  logic                q_full
);
  import ledd_pkg::*;

  logic           f_vld_r;
  logic [CLW-1:0] col_r;
  logic           first_r;
  logic [17:0]    s_r;
  logic [CLW-1:0] fcol_r;
  logic           flast_r, ffirst_r, fframe_r;

  logic           acc;
  logic [CLW-1:0] cur_col;
  logic           cur_first, last_c;
  logic [17:0]    sum_c;
  logic [36:0]    lp;
  logic [8:0]     lum9;

  assign in_ready = !f_vld_r || !q_full;
  assign acc      = in_valid && in_ready;
  assign push     = f_vld_r && !q_full;

  // A frame start clears the raster position before this pixel is placed.
  assign cur_col   = in_data.frame_start ? '0 : col_r;
  assign cur_first = in_data.frame_start ? 1'b1 : first_r;
  assign last_c    = ((WW'(cur_col) + WW'(1)) >= width_eff);

  assign sum_c = {10'b0, in_data.red} * LUMA_KR + {10'b0, in_data.green} * LUMA_KG
               + {10'b0, in_data.blue} * LUMA_KB + LUMA_BIAS;

  assign lp   = 37'(s_r) * 37'(LUMA_RECIP);
  assign lum9 = lp[LUMA_SHIFT+8:LUMA_SHIFT];

  assign push_ctl.luma        = (lum9 > 9'd255) ? 8'hff : lum9[7:0];
  assign push_ctl.last        = flast_r;
  assign push_ctl.first_row   = ffirst_r;
  assign push_ctl.frame_start = fframe_r;
  assign push_col             = fcol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
      col_r   <= '0;
      first_r <= 1'b1;
    end else begin
      if (acc) begin
        f_vld_r <= 1'b1;
      end else if (push) begin
        f_vld_r <= 1'b0;
      end
      if (acc) begin
        col_r   <= last_c ? '0 : cur_col + 1'b1;
        first_r <= last_c ? 1'b0 : cur_first;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s_r      <= sum_c;
      fcol_r   <= cur_col;
      flast_r  <= last_c;
      ffirst_r <= cur_first;
      fframe_r <= in_data.frame_start;
    end
  end

endmodule

// File: design/ledd_div.sv
`include "assert_macros.svh"

module ledd_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [7:0]  divisor,
  output logic        done,
  output logic [7:0]  quotient
);
  import ledd_pkg::*;

  logic [7:0] rem_r, low_r;
  logic [2:0] cnt_r;
  logic       busy_r, done_r;
  logic [8:0] trial, diff;
  logic       ge;

  // Restoring division, one quotient bit per cycle. The upper dividend byte is
  // always below the divisor, so the quotient fits eight bits.
  assign trial    = {rem_r, low_r[7]};
  assign diff     = trial - {1'b0, divisor};
  assign ge       = (trial >= {1'b0, divisor});
  assign done     = done_r;
  assign quotient = low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd7;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 3'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[15:8];
      low_r <= dividend[7:0];
    end else if (busy_r) begin
      rem_r <= ge ? diff[7:0] : trial[7:0];
      low_r <= {low_r[6:0], ge};
    end
  end

  `ASSERT_IMPLIES(a_start_idle, start, !busy_r, "divider restarted while busy")

endmodule

// File: design/ledd_back.sv
`include "assert_macros.svh"

module ledd_back #(
  parameter int  MAX_WIDTH = 4096,
  localparam int CLW = $clog2(MAX_WIDTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ledd_pkg::item_ctl_t q_ctl,
  input  logic [CLW-1:0]      q_col,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic [7:0]          n_div,
  output logic                out_valid,
  input  logic                out_ready,
  output ledd_pkg::pix_out_t  out_data
);
  import ledd_pkg::*;

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_CALC  = 3'd1;
  localparam logic [2:0] B_RECIP = 3'd2;
  localparam logic [2:0] B_DIVST = 3'd3;
  localparam logic [2:0] B_DIV   = 3'd4;
  localparam logic [2:0] B_ERR   = 3'd5;
  localparam logic [2:0] B_LAST  = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [15:0] right_r, below_r, diag_r;
  logic        out_valid_r;
  pix_out_t    out_data_r;

  logic [7:0]         luma_r, idx_r, q_r;
  logic [CLW-1:0]     col_r;
  logic               last_r, first_r;
  logic [15:0]        rd_r, nb_r;
  logic signed [17:0] old_r;
  logic [19:0]        t_r;

  logic [15:0] row_mem [MAX_WIDTH];

  logic [15:0]        above;
  logic signed [17:0] old_c;
  logic [11:0]        v16;
  logic [19:0]        t_c;
  logic [32:0]        ip;
  logic [15:0]        dividend;
  logic signed [23:0] ex, s_r7, s_bl, s_be, s_br, sum_bl, nb_c;
  logic               commit, div_start, div_done;
  logic [7:0]         div_q;
  logic               wr_en;
  logic [CLW-1:0]     wr_addr;
  logic [15:0]        wr_data;

  assign q_pop     = (state_r == B_IDLE) && !q_empty;
  assign commit    = (state_r == B_ERR) && (!out_valid_r || out_ready);
  assign div_start = (state_r == B_DIVST);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign above = first_r ? 16'h0000 : rd_r;
  assign old_c = $signed({6'b0, luma_r, 4'b0})
               + $signed({{2{right_r[15]}}, right_r})
               + $signed({{2{above[15]}}, above});

  always_comb begin
    if (old_c < 18'sd0) begin
      v16 = 12'd0;
    end else if (old_c > $signed({6'b0, VAL_MAX})) begin
      v16 = VAL_MAX;
    end else begin
      v16 = old_c[11:0];
    end
  end

  assign t_c      = {8'b0, v16} * {12'b0, n_div} + IDX_BIAS;
  assign ip       = 33'(t_r[19:4]) * 33'(IDX_RECIP);
  assign dividend = {idx_r, 8'b0} - {8'b0, idx_r};

  assign ex     = $signed({{6{old_r[17]}}, old_r}) - $signed({12'b0, q_r, 4'b0});
  assign s_r7   = share(ex * K_RIGHT);
  assign s_bl   = share(ex * K_BL);
  assign s_be   = share(ex * K_BELOW);
  assign s_br   = share(ex * K_BR);
  assign sum_bl = sx24(below_r) + s_bl;
  assign nb_c   = sx24(diag_r) + s_be;

  // One write port: the below-left sum goes out on commit, and the last
  // pixel of a row writes its own column in the following cycle.
  assign wr_en   = (commit && (col_r != '0)) || (state_r == B_LAST);
  assign wr_addr = (state_r == B_LAST) ? col_r : col_r - 1'b1;
  assign wr_data = (state_r == B_LAST) ? nb_r : sat16(sum_bl);

  ledd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (n_div),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (!q_empty) state_nxt = B_CALC;
      B_CALC:  state_nxt = B_RECIP;
      B_RECIP: state_nxt = B_DIVST;
      B_DIVST: state_nxt = B_DIV;
      B_DIV:   if (div_done) state_nxt = B_ERR;
      B_ERR:   if (commit) state_nxt = last_r ? B_LAST : B_IDLE;
      B_LAST:  state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      right_r     <= '0;
      below_r     <= '0;
      diag_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop && q_ctl.frame_start) begin
        right_r <= '0;
        below_r <= '0;
        diag_r  <= '0;
      end else if (commit) begin
        if (last_r) begin
          right_r <= '0;
          below_r <= '0;
          diag_r  <= '0;
        end else begin
          right_r <= sat16(s_r7);
          below_r <= sat16(nb_c);
          diag_r  <= sat16(s_br);
        end
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      luma_r  <= q_ctl.luma;
      last_r  <= q_ctl.last;
      first_r <= q_ctl.first_row;
      col_r   <= q_col;
    end
    if (state_r == B_CALC) begin
      old_r <= old_c;
      t_r   <= t_c;
    end
    if (state_r == B_RECIP) begin
      idx_r <= ip[IDX_SHIFT+7:IDX_SHIFT];
    end
    if ((state_r == B_DIV) && div_done) begin
      q_r <= div_q;
    end
    if (commit) begin
      nb_r                <= sat16(nb_c);
      out_data_r.dithered <= q_r;
      out_data_r.luma     <= luma_r;
      out_data_r.row_end  <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[wr_addr] <= wr_data;
    end
    if (q_pop) begin
      rd_r <= row_mem[q_col];
    end
  end

  `ASSERT_IMPLIES(a_done_in_wait, div_done, state_r == B_DIV, "divider finished out of turn")
  `ASSERT_NEXT(a_row_end_write, commit && last_r, state_r == B_LAST, "row end write skipped")

endmodule

// File: design/luma_error_diffusion_dither.sv
// Channel  Dir  Beat payload                          Handshake
// in_      in   red, green, blue, frame_start         in_valid / in_ready
// out_     out  dithered, luma, row_end               out_valid / out_ready
// cfg_     in   line_width @ 0x0, levels @ 0x4        APB psel/penable/pwrite, pready high
//
// The back end handles one pixel at a time and adds a line store write on the last pixel of a row;
// the serial level divider (8 steps) and the single-port line store set its pace.
// The front end takes a beat every cycle until its four-entry queue is full.
// Reset is synchronous and active low; the line store is not cleared and needs none.
// A result beat held on out_ready stalls only the back end; input keeps flowing
// into the queue meanwhile.

module luma_error_diffusion_dither #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ledd_pkg::pix_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ledd_pkg::pix_out_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import ledd_pkg::*;

  localparam int CLW = $clog2(MAX_WIDTH);
  localparam int WW  = (CLW + 1 > 13) ? CLW + 1 : 13;
  localparam int DW  = $bits(item_ctl_t) + CLW;

  // Configuration registers. Only paddr[2] selects the register, so the four
  // byte addresses within each word alias onto it.
  logic [12:0] lw_r;
  logic [8:0]  lv_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_r <= LINE_WIDTH_RST;
      lv_r <= LEVELS_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_LEVELS) begin
        lv_r <= cfg_pwdata[8:0];
      end else begin
        lw_r <= cfg_pwdata[12:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_LINE_WIDTH) ? {19'b0, lw_r} : {23'b0, lv_r};

  // The row width is clamped to 1..MAX_WIDTH and the level count to 2..256;
  // the back end works with the number of steps between levels.
  logic [WW-1:0] width_eff;
  logic [7:0]    n_div;

  always_comb begin
    if (lw_r == 13'd0) begin
      width_eff = WW'(1);
    end else if (WW'(lw_r) > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = WW'(lw_r);
    end
  end

  always_comb begin
    logic [8:0] lm1;
    lm1 = lv_r - 9'd1;
    if (lv_r < 9'd2) begin
      n_div = 8'd1;
    end else if (lv_r > 9'd256) begin
      n_div = 8'd255;
    end else begin
      n_div = lm1[7:0];
    end
  end

  // Front end: luma and raster position. Queue: classified pixels. Back end:
  // quantisation and diffusion of the error through the line store.
  logic           push, pop, q_full, q_empty;
  item_ctl_t      push_ctl, q_ctl;
  logic [CLW-1:0] push_col, q_col;
  logic [DW-1:0]  q_dout;

  ledd_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .width_eff (width_eff),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_col  (push_col),
    .q_full    (q_full)
  );

  ledd_fifo #(
    .DW (DW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   ({push_ctl, push_col}),
    .full  (q_full),
    .pop   (pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign q_ctl = q_dout[DW-1:CLW];
  assign q_col = q_dout[CLW-1:0];

  ledd_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_ctl     (q_ctl),
    .q_col     (q_col),
    .q_empty   (q_empty),
    .q_pop     (pop),
    .n_div     (n_div),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the luma error-diffusion dither. Pixels go in as beats on the in_
// channel; every accepted beat is run through a behavioural copy of the dither held here
// (luma, level quantiser, Floyd-Steinberg spreading and the line store of errors). That
// copy queues the dithered value, luma and row end the block should return. The result channel is checked beat by
// beat against that queue. Registers are only touched when the pipeline has drained.
module tb;
  import ledd_pkg::*;

  localparam int LINE_MAX    = 4096;
  // Longest stretch without any accepted beat that a correct run can show. It lies well above
  // the deliberate output hold-off and the time one pixel takes, so this leaves a wide margin.
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_OFF    = 300;
  localparam int DRAIN_WAIT  = 20;

  typedef enum {TEX_NOISE, TEX_EXTREME, TEX_RAMP, TEX_FLAT} texture_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  pix_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  pix_out_t    out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  luma_error_diffusion_dither dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  // Shadow copies of the two registers, updated as they are written.
  logic [12:0] width_reg = LINE_WIDTH_RST;
  logic [8:0]  levels_reg = LEVELS_RST;

  // Diffusion state of the behavioural copy. All errors are in sixteenths of a gray step.
  int                 col_pos = 0;
  bit                 in_first_row = 1'b1;
  logic signed [15:0] right_err = '0;
  logic signed [15:0] below_acc = '0;
  logic signed [15:0] diag_err = '0;
  logic signed [15:0] line_err [LINE_MAX];
  bit                 line_written [LINE_MAX];

  pix_out_t expected_pixels[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int pixels_sent = 0;
  int pixels_checked = 0;
  int frames_sent = 0;
  int reg_writes = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // Share of an error for a weight of k sixteenths, rounded half up (floor of (e*k+8)/16).
  function automatic int fs_share(input int err, input int k);
    return (err * k + 8) >>> 4;
  endfunction

  // Stored error sums saturate to the signed 16-bit range.
  function automatic logic signed [15:0] clip16(input int v);
    int c;
    c = v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    return c[15:0];
  endfunction

  function automatic int clamped_col();
    return col_pos > LINE_MAX - 1 ? LINE_MAX - 1 : col_pos;
  endfunction

  // Runs one accepted pixel through the behavioural dither and queues its result.
  task automatic predict_pixel(input pix_in_t px);
    int       w, n, c, luma, acc, v, idx, q, err, nb;
    bit       last;
    pix_out_t res;
    if (px.frame_start) begin
      col_pos = 0;
      in_first_row = 1'b1;
      right_err = '0;
      below_acc = '0;
      diag_err = '0;
    end
    w = int'(width_reg);
    if (w < 1) w = 1;
    if (w > LINE_MAX) w = LINE_MAX;
    n = int'(levels_reg);
    if (n < 2) n = 2;
    if (n > 256) n = 256;
    n = n - 1;
    c = clamped_col();
    last = (c + 1 >= w);

    luma = (299 * int'(px.red) + 587 * int'(px.green) + 114 * int'(px.blue) + 500) / 1000;
    if (luma > 255) luma = 255;

    // Value to quantise: luma plus the error from the left and, below the first row, from above.
    acc = luma * 16 + int'(right_err) + (in_first_row ? 0 : int'(line_err[c]));
    v = acc < 0 ? 0 : (acc > 4080 ? 4080 : acc);
    idx = (v * n * 2 + 4080) / 8160;
    q = (255 * idx) / n;
    err = acc - q * 16;

    // The below-left share completes the entry for the previous column.
    if (c > 0) begin
      line_err[c - 1] = clip16(int'(below_acc) + fs_share(err, 3));
      line_written[c - 1] = 1'b1;
    end
    nb = int'(diag_err) + fs_share(err, 5);
    if (last) begin
      line_err[c] = clip16(nb);
      line_written[c] = 1'b1;
      right_err = '0;
      below_acc = '0;
      diag_err = '0;
      col_pos = 0;
      in_first_row = 1'b0;
    end else begin
      below_acc = clip16(nb);
      diag_err = clip16(fs_share(err, 1));
      right_err = clip16(fs_share(err, 7));
      col_pos = c + 1;
    end

    res.dithered = q[7:0];
    res.luma = luma[7:0];
    res.row_end = last;
    expected_pixels.push_back(res);
  endtask

  // Sends one pixel beat. Entered and left just after a falling edge. A pixel that would
  // read a line store entry never written since reset is turned into the start of a frame.
  task automatic send_pixel(input pix_in_t px);
    if (!in_first_row && !line_written[clamped_col()]) px.frame_start = 1'b1;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (!in_ready);
    predict_pixel(px);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Drops valid, waits until every queued result has come back, then lets the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == REG_LINE_WIDTH) width_reg = value[12:0];
    else levels_reg = value[8:0];
    reg_writes++;
  endtask

  task automatic check_reg(input logic idx, input logic [31:0] want);
    logic [31:0] got;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == REG_LINE_WIDTH) begin
      if (got[12:0] !== want[12:0])
        report_mismatch($sformatf("line_width reads %0d, expected %0d", got[12:0], want[12:0]));
    end else begin
      if (got[8:0] !== want[8:0])
        report_mismatch($sformatf("levels reads %0d, expected %0d", got[8:0], want[8:0]));
    end
  endtask

  function automatic pix_in_t rgb(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b, input logic fs);
    pix_in_t p;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.frame_start = fs;
    return p;
  endfunction

  function automatic logic [7:0] near_rail();
    logic [7:0] rails [4] = '{8'h00, 8'h01, 8'hfe, 8'hff};
    return rails[$urandom_range(3)];
  endfunction

  function automatic pix_in_t make_pixel(input texture_e tex, input int k, input logic [7:0] base);
    pix_in_t p;
    case (tex)
      TEX_NOISE: begin
        p = rgb(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      end
      TEX_EXTREME: begin
        p = rgb(near_rail(), near_rail(), near_rail(), 1'b0);
      end
      TEX_RAMP: begin
        p = rgb(base + 8'(k * 3), base + 8'(k), base - 8'(k * 2), 1'b0);
        p.green = p.green ^ 8'($urandom_range(3));
      end
      default: begin
        p = rgb(base, base, base, 1'b0);
      end
    endcase
    return p;
  endfunction

  // A frame is normally a start beat followed by plain pixels; a broken one scatters
  // frame starts at random instead.
  task automatic send_frame(input int len, input bit broken);
    texture_e   tex;
    logic [7:0] base;
    pix_in_t    p;
    tex = texture_e'($urandom_range(3));
    base = 8'($urandom);
    for (int k = 0; k < len; k++) begin
      p = make_pixel(tex, k, base);
      p.frame_start = broken ? ($urandom_range(7) == 0) : (k == 0);
      send_pixel(p);
    end
    frames_sent++;
  endtask

  // Mostly narrow rows so that many rows end and the line store is read back; now and then
  // the clamped extremes and the widest row.
  function automatic logic [31:0] random_width();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(1, 16);
    if (pick < 85) return $urandom_range(17, 64);
    if (pick < 89) return 0;
    if (pick < 93) return LINE_MAX;
    if (pick < 96) return 8191;
    return $urandom_range(LINE_MAX + 1, 8190);
  endfunction

  function automatic logic [31:0] random_levels();
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return 2;
    if (pick < 25) return 256;
    if (pick < 30) return $urandom_range(1);
    if (pick < 35) return $urandom_range(257, 511);
    if (pick < 70) return $urandom_range(3, 16);
    return $urandom_range(17, 255);
  endfunction

  // Receiver: stalls at the rate of the current phase, or holds off for a counted stretch
  // when a test asks for it.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: every result beat must match the oldest queued expectation.
  always @(posedge clk) begin : check_results
    pix_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected: dithered=%0d luma=%0d",
                                  out_data.dithered, out_data.luma));
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (out_data.dithered !== want.dithered || out_data.luma !== want.luma ||
            out_data.row_end !== want.row_end)
          report_mismatch($sformatf(
            "expected dithered=%0d luma=%0d row_end=%0b, got dithered=%0d luma=%0d row_end=%0b",
            want.dithered, want.luma, want.row_end,
            out_data.dithered, out_data.luma, out_data.row_end));
      end
    end
  end

  // Watchdog: ends the run if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reset values, then both registers at their extremes, read back.
  task automatic test_register_readback();
    check_reg(REG_LINE_WIDTH, 32'(LINE_WIDTH_RST));
    check_reg(REG_LEVELS, 32'(LEVELS_RST));
    write_reg(REG_LINE_WIDTH, 8191);
    write_reg(REG_LEVELS, 511);
    check_reg(REG_LINE_WIDTH, 8191);
    check_reg(REG_LEVELS, 511);
    write_reg(REG_LINE_WIDTH, 0);
    write_reg(REG_LEVELS, 0);
    check_reg(REG_LINE_WIDTH, 0);
    check_reg(REG_LEVELS, 0);
  endtask

  // Short hand-picked sequence: rail colours, alternating bit patterns, a restart in the
  // middle of a row, single-pixel rows, clamped widths and levels, and a row cut short when
  // the width shrinks under it.
  task automatic test_edge_pixels();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(REG_LINE_WIDTH, 3);
    write_reg(REG_LEVELS, 2);
    send_pixel(rgb(8'h00, 8'h00, 8'h00, 1'b1));
    send_pixel(rgb(8'hff, 8'hff, 8'hff, 1'b0));
    send_pixel(rgb(8'hff, 8'h00, 8'h00, 1'b0));
    send_pixel(rgb(8'h00, 8'hff, 8'h00, 1'b0));
    send_pixel(rgb(8'h00, 8'h00, 8'hff, 1'b0));
    send_pixel(rgb(8'haa, 8'h55, 8'haa, 1'b0));
    send_pixel(rgb(8'h55, 8'haa, 8'h55, 1'b1));
    send_pixel(rgb(8'd128, 8'd128, 8'd128, 1'b0));
    send_pixel(rgb(8'd1, 8'd254, 8'd1, 1'b1));
    wait_idle();
    write_reg(REG_LINE_WIDTH, 1);
    write_reg(REG_LEVELS, 256);
    send_pixel(rgb(8'd17, 8'd200, 8'd3, 1'b0));
    send_pixel(rgb(8'hff, 8'h00, 8'h00, 1'b0));
    send_pixel(rgb(8'd254, 8'd254, 8'd254, 1'b0));
    wait_idle();
    write_reg(REG_LINE_WIDTH, 0);
    write_reg(REG_LEVELS, 1);
    send_pixel(rgb(8'd100, 8'd100, 8'd100, 1'b0));
    send_pixel(rgb(8'd7, 8'd250, 8'd90, 1'b0));
    wait_idle();
    write_reg(REG_LINE_WIDTH, 8191);
    write_reg(REG_LEVELS, 511);
    send_pixel(rgb(8'd60, 8'd61, 8'd62, 1'b1));
    send_pixel(rgb(8'd200, 8'd10, 8'd250, 1'b0));
    wait_idle();
    write_reg(REG_LINE_WIDTH, 6);
    write_reg(REG_LEVELS, 4);
    send_pixel(rgb(8'd90, 8'd90, 8'd90, 1'b1));
    for (int k = 1; k < 6; k++) send_pixel(rgb(8'(k * 40), 8'(k * 30), 8'(k * 20), 1'b0));
    for (int k = 0; k < 3; k++) send_pixel(rgb(8'd140, 8'd150, 8'd160, 1'b0));
    wait_idle();
    // The row is at column 3 when the width drops to 3, so the next pixel must end it.
    write_reg(REG_LINE_WIDTH, 3);
    for (int k = 0; k < 3; k++) send_pixel(rgb(8'd33, 8'd66, 8'd99, 1'b0));
    wait_idle();
  endtask

  // Random frames under one idling mix, with a new register setting every few frames.
  task automatic test_random_frames(input int idle_pct, input int stall_pct, input int count);
    int done_items, frame_len, frames_left;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    done_items = 0;
    while (done_items < count) begin
      wait_idle();
      write_reg(REG_LINE_WIDTH, random_width());
      write_reg(REG_LEVELS, random_levels());
      frames_left = 1 + $urandom_range(2);
      while (frames_left > 0 && done_items < count) begin
        frame_len = $urandom_range(8, 90);
        if (frame_len > count - done_items) frame_len = count - done_items;
        send_frame(frame_len, $urandom_range(99) < 20);
        done_items += frame_len;
        frames_left--;
      end
    end
    wait_idle();
  endtask

  // The receiver holds off while the sender keeps offering beats, so the input queue fills
  // and in_ready must drop; nothing may be lost or duplicated once the hold-off ends.
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(REG_LINE_WIDTH, 5);
    write_reg(REG_LEVELS, 9);
    hold_left = HOLD_OFF;
    send_frame(20, 1'b0);
    wait_idle();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_register_readback();
    test_edge_pixels();
    test_random_frames(0, 0, 440);
    test_random_frames(68, 0, 440);
    test_random_frames(0, 68, 440);
    test_random_frames(12, 12, 440);
    test_output_hold_off();

    wait_idle();
    repeat (30) @(posedge clk);
    if (expected_pixels.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));

    $display("Sent %0d pixels in %0d frames with %0d register writes, checked %0d results.",
             pixels_sent, frames_sent, reg_writes, pixels_checked);
    $display("Idling mixes: none, sender, receiver, both; plus one long output hold-off; "
             , "%0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
